// ===== design/wbma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbma_pkg
// Shared sizes, field positions and lane control type for the wrench
// baseline moving-average core.
// ----------------------------------------------------------------------------
package wbma_pkg;

   // window length, a power of two so that the floored mean is a shift
   localparam int WINDOW      = 64;
   localparam int WIN_LOG     = $clog2(WINDOW);
   localparam int AXES        = 6;
   localparam int SAMPLE_W    = 24;
   localparam int OUT_W       = 25;
   localparam int SUM_W       = SAMPLE_W + WIN_LOG;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int SLOT_W      = WIN_LOG;

   localparam int FIFO_DEPTH  = 4;
   localparam int FPTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int REQ_DATA_W  = AXES * SAMPLE_W;
   localparam int REQ_USER_W  = 3;
   localparam int RES_W       = 2 * AXES * OUT_W;
   localparam int RSP_DATA_W  = ((RES_W + 7) / 8) * 8;

   // bit positions in req_tuser
   localparam int USER_OP      = 0;
   localparam int USER_PRESENT = 1;
   localparam int USER_INVALID = 2;

   // operation codes
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              base_add;
      logic              base_capture;
      logic              ring_wr;
      logic [SLOT_W-1:0] slot;
      logic              s1_upd;
      logic              s1_sub;
   } lane_ctl_type;

endpackage
`default_nettype wire

// ===== design/wbma_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbma_ctrl
// Sequencing for the axis lanes: baseline count, ring fill and slot,
// result flags down the pipe and input flow control from output credit.
// ----------------------------------------------------------------------------
module wbma_ctrl
   import wbma_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic [FCNT_W-1:0]     fifo_count,
   output lane_ctl_type               lane_ctl,
   output logic                       push
);

   logic              base_ready_ff, base_ready_in;
   logic [CNT_W-1:0]  base_count_ff, base_count_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              s1_upd_ff, s1_upd_in;
   logic              s1_sub_ff, s1_sub_in;
   logic              s1_emit_ff, s1_emit_in;
   logic              s2_emit_ff;
   logic [FCNT_W-1:0] occupancy;
   logic              accept;
   logic              sample_ok;

   // words already committed to the output queue
   assign occupancy  = fifo_count + FCNT_W'(s1_emit_ff) + FCNT_W'(s2_emit_ff);
   assign req_tready = occupancy < FCNT_W'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign sample_ok  = (req_tuser[USER_OP] == OP_SAMPLE) && req_tuser[USER_PRESENT]
                       && !req_tuser[USER_INVALID];
   assign push       = s2_emit_ff;

   always_comb begin
      base_ready_in         = base_ready_ff;
      base_count_in         = base_count_ff;
      fill_in               = fill_ff;
      slot_in               = slot_ff;
      s1_upd_in             = 1'b0;
      s1_sub_in             = 1'b0;
      s1_emit_in            = 1'b0;
      lane_ctl.clear        = 1'b0;
      lane_ctl.base_add     = 1'b0;
      lane_ctl.base_capture = 1'b0;
      lane_ctl.ring_wr      = 1'b0;
      lane_ctl.slot         = slot_ff;
      lane_ctl.s1_upd       = s1_upd_ff;
      lane_ctl.s1_sub       = s1_sub_ff;
      if (accept && (req_tuser[USER_OP] == OP_RESTART)) begin
         base_ready_in  = 1'b0;
         base_count_in  = '0;
         fill_in        = '0;
         slot_in        = '0;
         lane_ctl.clear = 1'b1;
      end else if (accept && sample_ok && !base_ready_ff) begin
         lane_ctl.base_add = 1'b1;
         base_count_in     = base_count_ff + 1'b1;
         if (base_count_in == CNT_W'(WINDOW)) begin
            lane_ctl.base_capture = 1'b1;
            base_ready_in         = 1'b1;
            fill_in               = '0;
            slot_in               = '0;
         end
      end else if (accept && sample_ok) begin
         lane_ctl.ring_wr = 1'b1;
         s1_upd_in        = 1'b1;
         s1_sub_in        = (fill_ff == CNT_W'(WINDOW));
         if (!s1_sub_in) begin
            fill_in = fill_ff + 1'b1;
         end
         s1_emit_in = (fill_in == CNT_W'(WINDOW));
         slot_in    = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ready_ff <= 1'b0;
         base_count_ff <= '0;
         fill_ff       <= '0;
         slot_ff       <= '0;
         s1_upd_ff     <= 1'b0;
         s1_sub_ff     <= 1'b0;
         s1_emit_ff    <= 1'b0;
         s2_emit_ff    <= 1'b0;
      end else begin
         base_ready_ff <= base_ready_in;
         base_count_ff <= base_count_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         s1_upd_ff     <= s1_upd_in;
         s1_sub_ff     <= s1_sub_in;
         s1_emit_ff    <= s1_emit_in;
         s2_emit_ff    <= s1_emit_ff;
      end
   end

endmodule
`default_nettype wire

// ===== design/wbma_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbma_lane
// One axis: baseline accumulator and mean, sample ring, running window sum
// and the two result differences.
// ----------------------------------------------------------------------------
module wbma_lane
   import wbma_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_ctl_type               lane_ctl,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic signed [OUT_W-1:0]         vs_ref,
   output logic signed [OUT_W-1:0]         vs_mean
);

   logic [SAMPLE_W-1:0]        ring_mem [WINDOW];

   logic signed [SUM_W-1:0]    base_sum_ff, base_sum_in;
   logic signed [SAMPLE_W-1:0] base_mean_ff, base_mean_in;
   logic signed [SUM_W-1:0]    win_sum_ff, win_sum_in;
   logic signed [SUM_W-1:0]    base_sum_next;
   logic signed [SUM_W-1:0]    base_shift;

   logic signed [SAMPLE_W-1:0] s1_old_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff;
   logic signed [SAMPLE_W-1:0] s1_base_ff;
   logic signed [SUM_W-1:0]    sub_val;
   logic signed [SUM_W-1:0]    sum_new;

   logic signed [SUM_W-1:0]    s2_sum_ff;
   logic signed [SAMPLE_W-1:0] s2_x_ff;
   logic signed [SAMPLE_W-1:0] s2_base_ff;
   logic signed [SUM_W-1:0]    win_shift;
   logic signed [SAMPLE_W-1:0] win_mean;

   // ring: read-first so the slot's oldest sample comes out as it is replaced
   always_ff @(posedge clock) begin
      if (lane_ctl.ring_wr) begin
         ring_mem[lane_ctl.slot] <= sample;
         s1_old_ff               <= ring_mem[lane_ctl.slot];
         s1_x_ff                 <= sample;
         s1_base_ff              <= base_mean_ff;
      end
   end

   always_comb begin
      base_sum_next = base_sum_ff + SUM_W'(sample);
      base_shift    = base_sum_next >>> WIN_LOG;
      sub_val       = lane_ctl.s1_sub ? SUM_W'(s1_old_ff) : SUM_W'(0);
      sum_new       = win_sum_ff + SUM_W'(s1_x_ff) - sub_val;

      base_sum_in  = base_sum_ff;
      base_mean_in = base_mean_ff;
      win_sum_in   = win_sum_ff;
      if (lane_ctl.clear) begin
         base_sum_in  = '0;
         base_mean_in = '0;
         win_sum_in   = '0;
      end else begin
         if (lane_ctl.base_add) begin
            base_sum_in = base_sum_next;
         end
         if (lane_ctl.base_capture) begin
            base_mean_in = base_shift[SAMPLE_W-1:0];
            win_sum_in   = '0;
         end else if (lane_ctl.s1_upd) begin
            win_sum_in = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sum_ff  <= '0;
         base_mean_ff <= '0;
         win_sum_ff   <= '0;
      end else begin
         base_sum_ff  <= base_sum_in;
         base_mean_ff <= base_mean_in;
         win_sum_ff   <= win_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctl.s1_upd) begin
         s2_sum_ff  <= sum_new;
         s2_x_ff    <= s1_x_ff;
         s2_base_ff <= s1_base_ff;
      end
   end

   // floored window mean and the two differences
   always_comb begin
      win_shift = s2_sum_ff >>> WIN_LOG;
      win_mean  = win_shift[SAMPLE_W-1:0];
      vs_ref    = OUT_W'(win_mean) - OUT_W'(s2_base_ff);
      vs_mean   = OUT_W'(s2_x_ff) - OUT_W'(win_mean);
   end

endmodule
`default_nettype wire

// ===== design/wbma_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbma_merge
// Gathers the six lane results into one word and queues it for the
// output channel.
// ----------------------------------------------------------------------------
module wbma_merge
   import wbma_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [AXES-1:0][OUT_W-1:0] ref_lanes,
   input  wire logic [AXES-1:0][OUT_W-1:0] mean_lanes,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_DATA_W-1:0]           rsp_tdata,
   output logic [FCNT_W-1:0]               fifo_count
);

   logic [RES_W-1:0]  fifo_ff [FIFO_DEPTH];
   logic [RES_W-1:0]  word;
   logic [FPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   logic              pop;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         word[a*OUT_W +: OUT_W]          = ref_lanes[a];
         word[(AXES+a)*OUT_W +: OUT_W]   = mean_lanes[a];
      end
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = RSP_DATA_W'(fifo_ff[rd_ptr_ff]);
   assign fifo_count = count_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FCNT_W'(push) - FCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/wrench_baseline_moving_average_core.sv =====
// a result word is registered through the s1 and s2 stages and the output queue after its sample word is taken
// throughput: one word per cycle; the lanes and the per-lane ring port take a
//   sample every cycle, and the four-entry output queue holds back input
// the first WINDOW good samples build the baseline and give no result
// reset is synchronous and clears counters, sums and the queue at once;
//   ring contents are not cleared since every slot is refilled before it is read
`default_nettype none
// ----------------------------------------------------------------------------
// wrench_baseline_moving_average_core
// Six-axis force/torque baseline and moving-average estimator: one lane per
// axis, a shared sequencer and a merging output queue.
// ----------------------------------------------------------------------------
module wrench_baseline_moving_average_core
   import wbma_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // fx_sample, fy_sample, fz_sample, tx_sample, ty_sample, tz_sample
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation, sensor_present, sample_invalid
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // fx..tz_vs_ref, fx..tz_vs_mean, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   lane_ctl_type                lane_ctl;
   logic                        push;
   logic [FCNT_W-1:0]           fifo_count;
   logic [AXES-1:0][OUT_W-1:0]  ref_lanes;
   logic [AXES-1:0][OUT_W-1:0]  mean_lanes;

   wbma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .fifo_count (fifo_count),
      .lane_ctl   (lane_ctl),
      .push       (push)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      logic signed [OUT_W-1:0] vs_ref;
      logic signed [OUT_W-1:0] vs_mean;

      wbma_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_ctl (lane_ctl),
         .sample   (req_tdata[a*SAMPLE_W +: SAMPLE_W]),
         .vs_ref   (vs_ref),
         .vs_mean  (vs_mean)
      );

      assign ref_lanes[a]  = vs_ref;
      assign mean_lanes[a] = vs_mean;
   end

   wbma_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .ref_lanes  (ref_lanes),
      .mean_lanes (mean_lanes),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fifo_count (fifo_count)
   );

endmodule
`default_nettype wire

// ===== design/wbma_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbma_checker
// Port-level checks for the wrench baseline moving-average core.
// ----------------------------------------------------------------------------
module wbma_checker
   import wbma_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // queue is empty after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word shown right after reset");

   // a stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // input is only held off while results are waiting
   a_ready_credit : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   // a result into an empty queue traces back through the s1 and s2 registers to a sample word
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result word without a matching sample word");

endmodule

bind wrench_baseline_moving_average_core wbma_checker u_wbma_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wrench baseline moving-average core. A
// word-level estimator in the bench follows every sample word the core
// takes (baseline build, ring fill, running window, restarts, ignored
// samples) and queues the expected window deltas. Each result word is
// checked axis by axis against the oldest queued one. Both stream sides
// idle in random bursts, with quiet stretches and a quiet tail.
// ----------------------------------------------------------------------------
module tb_top;
   import wbma_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_PRINTS  = 40;

   typedef logic [AXES-1:0][SAMPLE_W-1:0] axis_set_type;
   typedef struct packed {
      logic [AXES-1:0][OUT_W-1:0] vs_mean;
      logic [AXES-1:0][OUT_W-1:0] vs_ref;
   } wrench_delta_type;

   localparam logic [SAMPLE_W-1:0] AXIS_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] AXIS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // fx_sample, fy_sample, fz_sample, tx_sample, ty_sample, tz_sample
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // operation, sensor_present, sample_invalid
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // fx..tz_vs_ref, fx..tz_vs_mean, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // estimator copy kept by the bench
   bit         base_ready;
   int         base_count;
   longint     base_sum  [AXES];
   longint     base_mean [AXES];
   longint     ring_val  [WINDOW][AXES];
   longint     ring_sum  [AXES];
   int         ring_fill;
   int         ring_slot;

   wrench_delta_type pending_deltas[$];

   string axis_name [AXES] = '{"fx", "fy", "fz", "tx", "ty", "tz"};

   int errors       = 0;
   int cycles       = 0;
   int gap_pct      = 0;
   int stall_pct    = 0;
   int stall_left   = 0;
   int n_samples    = 0;
   int n_restarts   = 0;
   int n_ignored    = 0;
   int n_results    = 0;

   wrench_baseline_moving_average_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  pending_deltas.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      if (errors < MAX_PRINTS)
         $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
      errors++;
   endtask

   task automatic clear_estimator();
      base_ready = 1'b0;
      base_count = 0;
      ring_fill  = 0;
      ring_slot  = 0;
      for (int a = 0; a < AXES; a++) begin
         base_sum[a]  = 0;
         base_mean[a] = 0;
         ring_sum[a]  = 0;
      end
   endtask

   task automatic advance_estimator(input logic op, input logic present,
                                    input logic invalid, input axis_set_type x,
                                    output bit has_out, output wrench_delta_type d);
      longint v;
      longint m;
      longint diff;
      has_out = 1'b0;
      d = '0;
      if (op == OP_RESTART) begin
         clear_estimator();
         return;
      end
      if (!present || invalid)
         return;
      if (!base_ready) begin
         for (int a = 0; a < AXES; a++) begin
            v = $signed(x[a]);
            base_sum[a] += v;
         end
         if (base_count < WINDOW)
            base_count++;
         if (base_count >= WINDOW) begin
            for (int a = 0; a < AXES; a++) begin
               base_mean[a] = base_sum[a] >>> WIN_LOG;
               ring_sum[a]  = 0;
            end
            base_ready = 1'b1;
            ring_fill  = 0;
            ring_slot  = 0;
         end
         return;
      end
      if (ring_fill >= WINDOW) begin
         for (int a = 0; a < AXES; a++)
            ring_sum[a] -= ring_val[ring_slot][a];
      end else begin
         ring_fill++;
      end
      for (int a = 0; a < AXES; a++) begin
         v = $signed(x[a]);
         ring_val[ring_slot][a] = v;
         ring_sum[a] += v;
      end
      ring_slot = (ring_slot + 1) % WINDOW;
      if (ring_fill < WINDOW)
         return;
      has_out = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         v = $signed(x[a]);
         m = ring_sum[a] >>> WIN_LOG;
         diff = m - base_mean[a];
         d.vs_ref[a] = diff[OUT_W-1:0];
         diff = v - m;
         d.vs_mean[a] = diff[OUT_W-1:0];
      end
   endtask

   task automatic check_result(input logic [RSP_DATA_W-1:0] word);
      wrench_delta_type want;
      logic [OUT_W-1:0] got;
      if (pending_deltas.size() == 0) begin
         report_mismatch("unexpected result word", word[OUT_W-1:0], '0);
         return;
      end
      want = pending_deltas.pop_front();
      n_results++;
      for (int a = 0; a < AXES; a++) begin
         got = word[a*OUT_W +: OUT_W];
         if (got !== want.vs_ref[a])
            report_mismatch({axis_name[a], "_vs_ref"}, got, want.vs_ref[a]);
         got = word[(AXES+a)*OUT_W +: OUT_W];
         if (got !== want.vs_mean[a])
            report_mismatch({axis_name[a], "_vs_mean"}, got, want.vs_mean[a]);
      end
      if ((word >> RES_W) !== '0)
         report_mismatch("fill bits", OUT_W'(word >> RES_W), '0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result(rsp_tdata);
   end

   // one input word; valid stays high across back-to-back words
   task automatic send_word(input logic op, input logic present, input logic invalid,
                            input axis_set_type x);
      logic [REQ_USER_W-1:0] u;
      bit has_out;
      wrench_delta_type d;
      u = '0;
      u[USER_OP]      = op;
      u[USER_PRESENT] = present;
      u[USER_INVALID] = invalid;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tuser  <= u;
      do @(posedge clock); while (!req_tready);
      advance_estimator(op, present, invalid, x, has_out, d);
      if (has_out)
         pending_deltas.push_back(d);
      if (op == OP_RESTART)
         n_restarts++;
      else if (!present || invalid)
         n_ignored++;
      else
         n_samples++;
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_axis();
      case ($urandom_range(0, 9))
         0: return AXIS_MIN;
         1: return AXIS_MAX;
         2: return '0;
         3: return '1;
         4: return SAMPLE_W'($urandom_range(0, 511) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic axis_set_type rand_set();
      axis_set_type x;
      for (int a = 0; a < AXES; a++)
         x[a] = rand_axis();
      return x;
   endfunction

   function automatic axis_set_type split_set(input logic [AXES-1:0] hi_mask);
      axis_set_type x;
      for (int a = 0; a < AXES; a++)
         x[a] = hi_mask[a] ? AXIS_MAX : AXIS_MIN;
      return x;
   endfunction

   task automatic test_ignored_words();
      send_word(OP_SAMPLE, 1'b0, 1'b0, split_set('1));
      send_word(OP_SAMPLE, 1'b1, 1'b1, split_set('0));
      send_word(OP_SAMPLE, 1'b0, 1'b1, rand_set());
   endtask

   task automatic test_restart_words();
      send_word(OP_RESTART, 1'b1, 1'b1, '1);
      send_word(OP_RESTART, 1'b0, 1'b0, rand_set());
      send_word(OP_RESTART, 1'b1, 1'b0, split_set('0));
   endtask

   task automatic test_extreme_samples();
      send_word(OP_SAMPLE, 1'b1, 1'b0, split_set('1));
      send_word(OP_SAMPLE, 1'b1, 1'b0, split_set('0));
      send_word(OP_SAMPLE, 1'b1, 1'b0, '0);
      send_word(OP_SAMPLE, 1'b1, 1'b0, '1);
      send_word(OP_SAMPLE, 1'b1, 1'b0, split_set(6'b010101));
      send_word(OP_SAMPLE, 1'b1, 1'b0, split_set(6'b101010));
      for (int i = 0; i < 4; i++)
         send_word(OP_SAMPLE, 1'b1, 1'b0, rand_set());
   endtask

   // baseline of full-scale values, then a window swinging to the other rail
   task automatic test_saturated_windows();
      logic [AXES-1:0] hi_mask;
      hi_mask = AXES'($urandom);
      for (int round = 0; round < 2; round++) begin
         send_word(OP_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   rand_set());
         for (int i = 0; i < WINDOW; i++)
            send_word(OP_SAMPLE, 1'b1, 1'b0, split_set(hi_mask));
         for (int i = 0; i < WINDOW; i++)
            send_word(OP_SAMPLE, 1'b1, 1'b0, split_set(~hi_mask));
         for (int i = 0; i < 6; i++)
            send_word(OP_SAMPLE, 1'b1, 1'b0, split_set(hi_mask));
         hi_mask = ~hi_mask;
      end
   endtask

   task automatic test_random_traffic(input int count, input int quiet_tail);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (i >= count - quiet_tail) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (i % 60 == 0) begin
            pick      = $urandom_range(0, 2);
            gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            pick      = $urandom_range(0, 2);
            stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
         end
         pick = $urandom_range(0, 999);
         if (pick < 4)
            send_word(OP_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      rand_set());
         else if (pick < 40)
            send_word(OP_SAMPLE, 1'b0, 1'b0, rand_set());
         else if (pick < 75)
            send_word(OP_SAMPLE, 1'b1, 1'b1, rand_set());
         else if (pick < 100)
            send_word(OP_SAMPLE, 1'b0, 1'b1, rand_set());
         else
            send_word(OP_SAMPLE, 1'b1, 1'b0, rand_set());
      end
   endtask

   initial begin
      clear_estimator();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      gap_pct   = 20;
      stall_pct = 20;
      test_ignored_words();
      test_restart_words();
      test_ignored_words();
      test_extreme_samples();
      test_saturated_windows();
      test_random_traffic(650, 150);
      req_tvalid <= 1'b0;
      while (pending_deltas.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d samples, %0d restarts, %0d ignored words", n_samples,
               n_restarts, n_ignored);
      $display("checked %0d result words, %0d mismatches", n_results, errors);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
